FILE: rtl/rtcat_pkg.sv
// Shared widths, codes and the result record of the real-time clock with alarm table.
package rtcat_pkg;

    // Field widths of the input and result items.
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 5;
    localparam int VAL_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int RSLOT_W = 4;
    localparam int KIND_W  = 2;

    // Default size of the alarm table.
    localparam int ALARM_SLOTS_DEF = 8;

    // Wrap limits of the time-of-day counters.
    localparam int HOUR_LIMIT = 24;
    localparam int MIN_LIMIT  = 60;
    localparam int SEC_LIMIT  = 60;

    // Input operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_SET_TIME  = 3'd1,
        OP_SET_ALARM = 3'd2,
        OP_CLR_ALARM = 3'd3,
        OP_RD_ALARM  = 3'd4
    } t_op;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_TIME  = 2'd0,
        KIND_ALARM = 2'd1,
        KIND_REPLY = 2'd2
    } t_kind;

    // Reply status codes.
    localparam logic STAT_OK     = 1'b0;
    localparam logic STAT_REJECT = 1'b1;

    // One result item as it is held inside the block.
    typedef struct packed {
        t_kind              kind;
        logic [HOUR_W-1:0]  cur_hour;
        logic [MIN_W-1:0]   cur_minute;
        logic [SEC_W-1:0]   cur_second;
        logic               half_flag;
        logic [RSLOT_W-1:0] result_slot;
        logic               status;
        logic [VAL_W-1:0]   alarm_hour_out;
        logic [VAL_W-1:0]   alarm_minute_out;
        logic               alarm_on;
        logic               last;
    } t_result;

endpackage

FILE: rtl/rtcat_if.sv
// Valid/ready channel interfaces for the input items and the result items.
interface rtcat_in_if import rtcat_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]         hour_value;
    logic [VAL_W-1:0]         minute_value;
    logic [VAL_W-1:0]         second_value;

    modport source (
        output valid, op, slot, hour_value, minute_value, second_value,
        input  ready
    );
    modport sink (
        input  valid, op, slot, hour_value, minute_value, second_value,
        output ready
    );
endinterface

interface rtcat_out_if import rtcat_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [HOUR_W-1:0]  cur_hour;
    logic [MIN_W-1:0]   cur_minute;
    logic [SEC_W-1:0]   cur_second;
    logic               half_flag;
    logic [RSLOT_W-1:0] result_slot;
    logic               status;
    logic [VAL_W-1:0]   alarm_hour_out;
    logic [VAL_W-1:0]   alarm_minute_out;
    logic               alarm_on;
    logic               last;

    modport source (
        output valid, kind, cur_hour, cur_minute, cur_second, half_flag, result_slot,
               status, alarm_hour_out, alarm_minute_out, alarm_on, last,
        input  ready
    );
    modport sink (
        input  valid, kind, cur_hour, cur_minute, cur_second, half_flag, result_slot,
               status, alarm_hour_out, alarm_minute_out, alarm_on, last,
        output ready
    );
endinterface

FILE: rtl/rtc_with_alarm_table.sv
// Time-of-day clock with half-second ticks and a serially scanned alarm table.
//
// Usage: items enter on i_in (op, slot, hour/minute/second values) and results leave
// on o_out, both as valid/ready channels; a transfer happens when valid and ready are
// both high at a rising edge. A tick item yields a time report and, on the full-second
// phase when the seconds wrap to zero, one alarm result per matching enabled slot in
// ascending slot order. Each command yields exactly one reply. The last result of an
// item carries last = 1; ops 5 to 7 yield nothing.
// Timing: the block takes one item at a time; i_in.ready is high only while idle.
// A command or a tick without scan passes through S_EXEC and S_FLUSH; its result moves
// from the pending register to the output register. A scanning tick, and set alarm with
// a negative slot, use one shared normalize-and-compare unit (or the free-slot test)
// that visits one table slot per cycle; the scan holds on a match while o_out stalls.
// Stalls: results pass through a pending register and an output register; while
// o_out.ready is low the scan holds on a matching slot and the block stays busy.
// Reset (i_rst_n low at a rising edge) clears the time, the phase and the whole alarm
// table, and drops any result in flight.
module rtc_with_alarm_table import rtcat_pkg::*; #(
    parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rtcat_in_if.sink       i_in,
    rtcat_out_if.source    o_out
);

    localparam int IDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALARM_SLOTS - 1);

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FREE  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [SEC_W-1:0]    r_sec, n_sec;
    logic [MIN_W-1:0]    r_min, n_min;
    logic [HOUR_W-1:0]   r_hour, n_hour;
    logic                r_half, n_half;
    logic [VAL_W-1:0]    r_al_hour [ALARM_SLOTS];
    logic [VAL_W-1:0]    n_al_hour [ALARM_SLOTS];
    logic [VAL_W-1:0]    r_al_min [ALARM_SLOTS];
    logic [VAL_W-1:0]    n_al_min [ALARM_SLOTS];
    logic [ALARM_SLOTS-1:0] r_al_en, n_al_en;
    logic [OP_W-1:0]     r_op, n_op;
    logic                r_neg, n_neg;
    logic                r_slot_ok, n_slot_ok;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [VAL_W-1:0]    r_hv, n_hv;
    logic [VAL_W-1:0]    r_mv, n_mv;
    logic [VAL_W-1:0]    r_sv, n_sv;
    t_result             r_pend, n_pend;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                w_out_free;
    logic                w_slot_ok;
    logic [VAL_W-1:0]    w_rd_hour;
    logic [VAL_W-1:0]    w_rd_min;
    logic                w_rd_en;
    logic [VAL_W:0]      w_norm_hour;
    logic [VAL_W-1:0]    w_norm_min;
    logic                w_match;

    // Builds a result record with the given kind and time, all other fields zero.
    function automatic t_result mk_res(input t_kind k, input logic [HOUR_W-1:0] h,
                                       input logic [MIN_W-1:0] m,
                                       input logic [SEC_W-1:0] s);
        t_result res;
        res            = '0;
        res.kind       = k;
        res.cur_hour   = h;
        res.cur_minute = m;
        res.cur_second = s;
        return res;
    endfunction

    // Handshake and port drive.
    assign w_out_free            = !r_out_valid || o_out.ready;
    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.cur_hour        = r_out.cur_hour;
    assign o_out.cur_minute      = r_out.cur_minute;
    assign o_out.cur_second      = r_out.cur_second;
    assign o_out.half_flag       = r_out.half_flag;
    assign o_out.result_slot     = r_out.result_slot;
    assign o_out.status          = r_out.status;
    assign o_out.alarm_hour_out  = r_out.alarm_hour_out;
    assign o_out.alarm_minute_out = r_out.alarm_minute_out;
    assign o_out.alarm_on        = r_out.alarm_on;
    assign o_out.last            = r_out.last;

    // A slot is usable when it is not negative and lies inside the table.
    assign w_slot_ok = !i_in.slot[SLOT_W-1] &&
                       ({1'b0, i_in.slot[RSLOT_W-1:0]} < SLOT_W'(ALARM_SLOTS));

    // The table is read at the single sequencer address.
    assign w_rd_hour = r_al_hour[r_idx];
    assign w_rd_min  = r_al_min[r_idx];
    assign w_rd_en   = r_al_en[r_idx];

    // Shared unit: wrap the stored alarm time and compare it with the clock.
    always_comb begin
        w_norm_hour = {1'b0, w_rd_hour};
        w_norm_min  = w_rd_min;
        if (w_rd_min >= VAL_W'(MIN_LIMIT)) begin
            w_norm_min  = w_rd_min - VAL_W'(MIN_LIMIT);
            w_norm_hour = w_norm_hour + (VAL_W+1)'(1);
        end
        if (w_norm_hour >= (VAL_W+1)'(HOUR_LIMIT)) begin
            w_norm_hour = w_norm_hour - (VAL_W+1)'(HOUR_LIMIT);
        end
        w_match = w_rd_en && (w_norm_hour == (VAL_W+1)'(r_hour)) &&
                  (w_norm_min == r_min);
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        n_state     = r_state;
        n_sec       = r_sec;
        n_min       = r_min;
        n_hour      = r_hour;
        n_half      = r_half;
        n_al_hour   = r_al_hour;
        n_al_min    = r_al_min;
        n_al_en     = r_al_en;
        n_op        = r_op;
        n_neg       = r_neg;
        n_slot_ok   = r_slot_ok;
        n_idx       = r_idx;
        n_hv        = r_hv;
        n_mv        = r_mv;
        n_sv        = r_sv;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // The receiver took the held result.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op      = i_in.op;
                    n_neg     = i_in.slot[SLOT_W-1];
                    n_slot_ok = w_slot_ok;
                    n_idx     = w_slot_ok ? i_in.slot[IDX_W-1:0] : '0;
                    n_hv      = i_in.hour_value;
                    n_mv      = i_in.minute_value;
                    n_sv      = i_in.second_value;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_state = S_FLUSH;
                case (r_op)
                    OP_TICK: begin
                        n_half = !r_half;
                        if (!r_half) begin
                            // Half phase: report the unchanged time.
                            n_pend           = mk_res(KIND_TIME, r_hour, r_min, r_sec);
                            n_pend.half_flag = 1'b1;
                        end else begin
                            // Full phase: advance seconds, minutes and hours.
                            if (r_sec >= SEC_W'(SEC_LIMIT - 1)) begin
                                n_sec = '0;
                                if (r_min >= MIN_W'(MIN_LIMIT - 1)) begin
                                    n_min = '0;
                                    if (r_hour >= HOUR_W'(HOUR_LIMIT - 1)) begin
                                        n_hour = '0;
                                    end else begin
                                        n_hour = r_hour + HOUR_W'(1);
                                    end
                                end else begin
                                    n_min = r_min + MIN_W'(1);
                                end
                            end else begin
                                n_sec = r_sec + SEC_W'(1);
                            end
                            n_pend = mk_res(KIND_TIME, n_hour, n_min, n_sec);
                            if (n_sec == '0) begin
                                n_idx   = '0;
                                n_state = S_SCAN;
                            end
                        end
                    end

                    OP_SET_TIME: begin
                        if (r_hv >= VAL_W'(HOUR_LIMIT) || r_mv >= VAL_W'(MIN_LIMIT) ||
                            r_sv >= VAL_W'(SEC_LIMIT)) begin
                            n_pend        = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                            n_pend.status = STAT_REJECT;
                        end else begin
                            n_hour = r_hv[HOUR_W-1:0];
                            n_min  = r_mv;
                            n_sec  = r_sv;
                            n_pend = mk_res(KIND_REPLY, r_hv[HOUR_W-1:0], r_mv, r_sv);
                        end
                    end

                    OP_SET_ALARM: begin
                        if (r_neg) begin
                            n_idx   = '0;
                            n_state = S_FREE;
                        end else if (r_slot_ok) begin
                            n_al_hour[r_idx]   = r_hv;
                            n_al_min[r_idx]    = r_mv;
                            n_al_en[r_idx]     = 1'b1;
                            n_pend             = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                            n_pend.result_slot = RSLOT_W'(r_idx);
                        end else begin
                            n_pend        = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                            n_pend.status = STAT_REJECT;
                        end
                    end

                    OP_CLR_ALARM: begin
                        n_pend = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                        if (r_slot_ok) begin
                            n_al_en[r_idx]     = 1'b0;
                            n_pend.result_slot = RSLOT_W'(r_idx);
                        end else begin
                            n_pend.status = STAT_REJECT;
                        end
                    end

                    OP_RD_ALARM: begin
                        n_pend = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                        if (r_slot_ok) begin
                            n_pend.result_slot      = RSLOT_W'(r_idx);
                            n_pend.alarm_hour_out   = w_rd_hour;
                            n_pend.alarm_minute_out = w_rd_min;
                            n_pend.alarm_on         = w_rd_en;
                        end else begin
                            n_pend.status = STAT_REJECT;
                        end
                    end

                    default: begin
                        // Unknown operation: no result at all.
                        n_state = S_IDLE;
                    end
                endcase
            end

            S_FREE: begin
                // Look for the lowest slot that is not enabled, one slot a cycle.
                if (!w_rd_en) begin
                    n_al_hour[r_idx]   = r_hv;
                    n_al_min[r_idx]    = r_mv;
                    n_al_en[r_idx]     = 1'b1;
                    n_pend             = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                    n_pend.result_slot = RSLOT_W'(r_idx);
                    n_state            = S_FLUSH;
                end else if (r_idx == LAST_IDX) begin
                    n_pend        = mk_res(KIND_REPLY, r_hour, r_min, r_sec);
                    n_pend.status = STAT_REJECT;
                    n_state       = S_FLUSH;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            S_SCAN: begin
                // A match pushes the pending result out and takes its place.
                if (!w_match || w_out_free) begin
                    if (w_match) begin
                        n_out              = r_pend;
                        n_out.last         = 1'b0;
                        n_out_valid        = 1'b1;
                        n_pend             = mk_res(KIND_ALARM, r_hour, r_min, r_sec);
                        n_pend.result_slot = RSLOT_W'(r_idx);
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end

            S_FLUSH: begin
                // The pending result is the final one of this item.
                if (w_out_free) begin
                    n_out       = r_pend;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers; the alarm table and the clock reset to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_half      <= 1'b0;
            r_al_en     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ALARM_SLOTS; i++) begin
                r_al_hour[i] <= '0;
                r_al_min[i]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_sec       <= n_sec;
            r_min       <= n_min;
            r_hour      <= n_hour;
            r_half      <= n_half;
            r_al_en     <= n_al_en;
            r_out_valid <= n_out_valid;
            r_al_hour   <= n_al_hour;
            r_al_min    <= n_al_min;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_neg     <= n_neg;
        r_slot_ok <= n_slot_ok;
        r_idx     <= n_idx;
        r_hv      <= n_hv;
        r_mv      <= n_mv;
        r_sv      <= n_sv;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

endmodule

FILE: bench/rtcat_checker.sv
// Checker that watches both channels, predicts every result of the clock and compares it.
module rtcat_checker import rtcat_pkg::*; #(
    parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rtcat_in_if   i_in_mon,
    rtcat_out_if  i_out_mon,
    output int    o_fail_count,
    output int    o_outstanding
);

    // Predicted time of day, phase and alarm table.
    logic [SEC_W-1:0]  sec_q;
    logic [MIN_W-1:0]  min_q;
    logic [HOUR_W-1:0] hour_q;
    logic              half_q;
    logic [VAL_W-1:0]  alm_hour [ALARM_SLOTS];
    logic [VAL_W-1:0]  alm_min  [ALARM_SLOTS];
    logic              alm_on   [ALARM_SLOTS];

    // Results that the clock still owes, oldest first.
    t_result due_results[$];
    int      fail_cnt = 0;

    // Builds one result carrying the current predicted time.
    function automatic t_result clock_record(t_kind kind, logic half, int rslot, logic status,
                                             int ah, int am, logic on);
        t_result r;
        r.kind             = kind;
        r.cur_hour         = hour_q;
        r.cur_minute       = min_q;
        r.cur_second       = sec_q;
        r.half_flag        = half;
        r.result_slot      = RSLOT_W'(rslot);
        r.status           = status;
        r.alarm_hour_out   = VAL_W'(ah);
        r.alarm_minute_out = VAL_W'(am);
        r.alarm_on         = on;
        r.last             = 1'b0;
        return r;
    endfunction

    function automatic string describe_result(t_result r);
        return $sformatf({"kind=%0d time=%0d:%0d:%0d half=%0d slot=%0d status=%0d ",
                          "alarm=%0d:%0d on=%0d last=%0d"},
                         r.kind, r.cur_hour, r.cur_minute, r.cur_second, r.half_flag,
                         r.result_slot, r.status, r.alarm_hour_out, r.alarm_minute_out,
                         r.alarm_on, r.last);
    endfunction

    // Applies one accepted item to the predicted state and queues the results it causes.
    task automatic apply_rtc_item(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot_raw,
                                  input logic [VAL_W-1:0] hv, input logic [VAL_W-1:0] mv,
                                  input logic [VAL_W-1:0] sv);
        t_result produced[$];
        logic    neg;
        int      idx;
        bit      slot_ok;
        int      ah;
        int      am;
        int      nxt;
        neg     = slot_raw[SLOT_W-1];
        idx     = int'(slot_raw[SLOT_W-2:0]);
        slot_ok = !neg && idx < ALARM_SLOTS;
        case (op)
            OP_TICK: begin
                half_q = ~half_q;
                if (half_q) begin
                    produced.push_back(clock_record(KIND_TIME, 1'b1, 0, STAT_OK, 0, 0, 1'b0));
                end else begin
                    // Full second: advance the counters with their wraps.
                    nxt = int'(sec_q) + 1;
                    if (nxt >= SEC_LIMIT) begin
                        sec_q = '0;
                        nxt = int'(min_q) + 1;
                        if (nxt >= MIN_LIMIT) begin
                            min_q = '0;
                            nxt = int'(hour_q) + 1;
                            hour_q = (nxt >= HOUR_LIMIT) ? '0 : HOUR_W'(nxt);
                        end else begin
                            min_q = MIN_W'(nxt);
                        end
                    end else begin
                        sec_q = SEC_W'(nxt);
                    end
                    produced.push_back(clock_record(KIND_TIME, 1'b0, 0, STAT_OK, 0, 0, 1'b0));
                    // On a new minute, scan the enabled alarms in slot order.
                    if (sec_q == '0) begin
                        for (int i = 0; i < ALARM_SLOTS; i++) begin
                            if (alm_on[i]) begin
                                ah = int'(alm_hour[i]);
                                am = int'(alm_min[i]);
                                if (am >= MIN_LIMIT) begin
                                    am = am - MIN_LIMIT;
                                    ah = ah + 1;
                                end
                                if (ah >= HOUR_LIMIT) ah = ah - HOUR_LIMIT;
                                if (ah == int'(hour_q) && am == int'(min_q)) begin
                                    produced.push_back(clock_record(KIND_ALARM, 1'b0, i,
                                                                    STAT_OK, 0, 0, 1'b0));
                                end
                            end
                        end
                    end
                end
            end
            OP_SET_TIME: begin
                if (hv >= HOUR_LIMIT || mv >= MIN_LIMIT || sv >= SEC_LIMIT) begin
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, 0, STAT_REJECT,
                                                    0, 0, 1'b0));
                end else begin
                    hour_q = HOUR_W'(hv);
                    min_q  = MIN_W'(mv);
                    sec_q  = SEC_W'(sv);
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, 0, STAT_OK, 0, 0, 1'b0));
                end
            end
            OP_SET_ALARM: begin
                // A negative slot takes the lowest slot that is not enabled.
                if (neg) begin
                    for (int i = 0; i < ALARM_SLOTS; i++) begin
                        if (!slot_ok && !alm_on[i]) begin
                            idx     = i;
                            slot_ok = 1'b1;
                        end
                    end
                end
                if (slot_ok) begin
                    alm_hour[idx] = hv;
                    alm_min[idx]  = mv;
                    alm_on[idx]   = 1'b1;
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, idx, STAT_OK,
                                                    0, 0, 1'b0));
                end else begin
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, 0, STAT_REJECT,
                                                    0, 0, 1'b0));
                end
            end
            OP_CLR_ALARM: begin
                if (slot_ok) begin
                    alm_on[idx] = 1'b0;
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, idx, STAT_OK,
                                                    0, 0, 1'b0));
                end else begin
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, 0, STAT_REJECT,
                                                    0, 0, 1'b0));
                end
            end
            OP_RD_ALARM: begin
                if (slot_ok) begin
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, idx, STAT_OK,
                                                    int'(alm_hour[idx]), int'(alm_min[idx]),
                                                    alm_on[idx]));
                end else begin
                    produced.push_back(clock_record(KIND_REPLY, 1'b0, 0, STAT_REJECT,
                                                    0, 0, 1'b0));
                end
            end
            default: begin
                // Unknown operations cause nothing.
            end
        endcase
        if (produced.size() > 0) begin
            produced[produced.size()-1].last = 1'b1;
            foreach (produced[k]) due_results.push_back(produced[k]);
        end
    endtask

    // Predict on each input transfer, then compare each output transfer with the oldest result.
    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            sec_q  = '0;
            min_q  = '0;
            hour_q = '0;
            half_q = 1'b0;
            for (int i = 0; i < ALARM_SLOTS; i++) begin
                alm_hour[i] = '0;
                alm_min[i]  = '0;
                alm_on[i]   = 1'b0;
            end
            due_results.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                apply_rtc_item(i_in_mon.op, i_in_mon.slot, i_in_mon.hour_value,
                               i_in_mon.minute_value, i_in_mon.second_value);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.kind             = t_kind'(i_out_mon.kind);
                got.cur_hour         = i_out_mon.cur_hour;
                got.cur_minute       = i_out_mon.cur_minute;
                got.cur_second       = i_out_mon.cur_second;
                got.half_flag        = i_out_mon.half_flag;
                got.result_slot      = i_out_mon.result_slot;
                got.status           = i_out_mon.status;
                got.alarm_hour_out   = i_out_mon.alarm_hour_out;
                got.alarm_minute_out = i_out_mon.alarm_minute_out;
                got.alarm_on         = i_out_mon.alarm_on;
                got.last             = i_out_mon.last;
                if (due_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time, describe_result(got));
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, describe_result(want), describe_result(got));
                    end
                end
            end
        end
        o_outstanding <= due_results.size();
        o_fail_count  <= fail_cnt;
    end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the clock with alarm table: stimulus, output stalls and the verdict.
module tb_top;
    import rtcat_pkg::*;

    localparam int SLOTS        = ALARM_SLOTS_DEF;
    localparam int RANDOM_ITEMS = 130;
    localparam int LONG_HOLD    = 100;
    localparam int DRAIN_CYCLES = 3 * (3 + SLOTS);
    localparam int CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_toggle = 1'b0;
    int   fail_count;
    int   outstanding;
    int   burst_left = 0;
    int   sent_count = 0;

    rtcat_in_if  in_ch();
    rtcat_out_if out_ch();

    rtc_with_alarm_table #(.ALARM_SLOTS(SLOTS)) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rtcat_checker #(.ALARM_SLOTS(SLOTS)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_mon      (in_ch),
        .i_out_mon     (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Offers one item, with a random gap between bursts, and waits for its transfer.
    task automatic send_item(input logic [OP_W-1:0] op, input int slot, input int hv,
                             input int mv, input int sv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.op           <= op;
        in_ch.slot         <= slot[SLOT_W-1:0];
        in_ch.hour_value   <= hv[VAL_W-1:0];
        in_ch.minute_value <= mv[VAL_W-1:0];
        in_ch.second_value <= sv[VAL_W-1:0];
        do @(posedge clk); while (!in_ch.ready);
        if (op <= OP_RD_ALARM) sent_count++;
    endtask

    // A tick carries don't-care fields, so they are filled at random.
    task automatic send_tick();
        send_item(OP_TICK, int'($urandom_range(0, 31)) - 16, $urandom_range(0, 63),
                  $urandom_range(0, 63), $urandom_range(0, 63));
    endtask

    // Sets the clock one second before hh:mm:00 so that the next full tick scans the alarms.
    task automatic set_time_before(input int th, input int tm);
        if (tm == 0) send_item(OP_SET_TIME, 0, (th == 0) ? 23 : th - 1, 59, 59);
        else send_item(OP_SET_TIME, 0, th, tm - 1, 59);
    endtask

    // Lowers valid and waits until every predicted result has been transferred.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Receiver: ready follows one of four patterns in turn, or holds off on request.
    initial begin : receiver
        int   cyc;
        int   hold_left;
        logic hold_seen;
        logic rdy;
        cyc       = 0;
        hold_left = 0;
        hold_seen = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case ((cyc / 64) % 4)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ((cyc % 7) >= 3);
                    default: rdy = 1'($urandom_range(0, 1));
                endcase
            end
            out_ch.ready <= rdy;
        end
    end

    // Ends a run that hangs.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus: reset, directed cases, then random sequences.
    initial begin : stimulus
        int         th;
        int         tm;
        int         ah;
        int         am;
        int         pick;
        int         slot;
        logic [1:0] form;
        bit         hold_done;
        bit         pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        rst_n              <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.op           <= OP_TICK;
        in_ch.slot         <= '0;
        in_ch.hour_value   <= '0;
        in_ch.minute_value <= '0;
        in_ch.second_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset contents, both phases, set time at its limits and rejected times.
        send_item(OP_RD_ALARM, 0, 0, 0, 0);
        send_tick();
        send_tick();
        send_item(OP_SET_TIME, 0, 23, 59, 58);
        send_item(OP_SET_TIME, 0, 24, 0, 0);
        send_item(OP_SET_TIME, 0, 0, 60, 0);
        send_item(OP_SET_TIME, 0, 0, 0, 60);
        send_item(OP_SET_TIME, 0, 63, 63, 63);
        // Alarm at midnight, a free-slot pick with minute overflow, an alarm that never matches.
        send_item(OP_SET_ALARM, 0, 0, 0, 0);
        send_item(OP_SET_ALARM, -1, 23, 61, 0);
        send_item(OP_SET_ALARM, SLOTS - 1, 63, 63, 0);
        // Slots out of range and negative slots on clear and read.
        send_item(OP_SET_ALARM, SLOTS, 1, 1, 0);
        send_item(OP_CLR_ALARM, -1, 0, 0, 0);
        send_item(OP_RD_ALARM, -16, 0, 0, 0);
        // Cross midnight; the alarm in slot zero fires.
        repeat (4) send_tick();
        send_item(OP_RD_ALARM, 1, 0, 0, 0);
        send_item(OP_CLR_ALARM, SLOTS - 1, 0, 0, 0);
        send_item(OP_RD_ALARM, SLOTS - 1, 0, 0, 0);
        // Unknown operations are ignored.
        send_item(3'd5, 15, 63, 63, 63);
        send_item(3'd7, -16, 0, 0, 0);
        // The overflowing alarm matches at 00:01.
        send_item(OP_SET_TIME, 0, 0, 0, 59);
        send_tick();
        send_tick();

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS) begin
            // Long receiver hold-off while items keep coming.
            if (!hold_done && sent_count >= 50) begin
                hold_toggle <= ~hold_toggle;
                hold_done = 1'b1;
            end
            // Sender pause until everything has been transferred.
            if (!pause_done && sent_count >= 110) begin
                wait_drained();
                pause_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            th   = $urandom_range(0, 23);
            tm   = $urandom_range(0, 59);
            if (pick < 40) begin
                // A few alarms for one minute, in plain or overflowing form, then reach it.
                repeat ($urandom_range(1, 4)) begin
                    ah   = th;
                    am   = tm;
                    form = 2'($urandom_range(0, 3));
                    if (form[0] && tm <= 3) begin
                        am = tm + 60;
                        ah = (th == 0) ? 23 : th - 1;
                    end
                    if (form[1]) ah = ah + 24;
                    slot = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, SLOTS - 1);
                    send_item(OP_SET_ALARM, slot, ah, am, $urandom_range(0, 63));
                end
                set_time_before(th, tm);
                repeat ($urandom_range(2, 3)) send_tick();
                if ($urandom_range(0, 1)) begin
                    send_item(OP_RD_ALARM, $urandom_range(0, SLOTS - 1), 0, 0, 0);
                end
            end else if (pick < 55) begin
                // Let the clock run, often across a midnight wrap.
                if ($urandom_range(0, 2) == 0) begin
                    send_item(OP_SET_TIME, 0, 23, 59, $urandom_range(56, 59));
                end else begin
                    send_item(OP_SET_TIME, 0, th, tm, $urandom_range(0, 59));
                end
                repeat ($urandom_range(2, 8)) send_tick();
            end else if (pick < 65) begin
                // Fill the table through free-slot picks until one is refused, then free some.
                repeat (SLOTS + 1) begin
                    send_item(OP_SET_ALARM, -int'($urandom_range(1, 16)),
                              $urandom_range(0, 63), $urandom_range(0, 63), 0);
                end
                repeat ($urandom_range(1, 3)) begin
                    send_item(OP_CLR_ALARM, $urandom_range(0, SLOTS - 1), 0, 0, 0);
                end
            end else if (pick < 75) begin
                // Every slot on one minute: the tick then yields the most results.
                for (int i = 0; i < SLOTS; i++) begin
                    send_item(OP_SET_ALARM, i, th, tm, $urandom_range(0, 63));
                end
                set_time_before(th, tm);
                send_tick();
                send_tick();
            end else begin
                // Noise: any operation with any field values.
                send_item(OP_W'($urandom_range(0, 7)), int'($urandom_range(0, 31)) - 16,
                          $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: rtc_with_alarm_table.f
rtl/rtcat_pkg.sv
rtl/rtcat_if.sv
rtl/rtc_with_alarm_table.sv
bench/rtcat_checker.sv
bench/tb_top.sv
